// ===== rtl/hkpr_pkg.sv =====
// ----------------------------------------------------------------------------
// hkpr_pkg
// Shared constants and types for the HID key press/release tracker.
// ----------------------------------------------------------------------------
package hkpr_pkg;

    localparam int MAX_HELD = 4;
    localparam int CNT_W    = $clog2(MAX_HELD + 1);
    localparam int IDX_W    = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
    localparam int KEY_W    = 16;

    localparam logic [1:0] CMD_BEGIN = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    localparam logic KIND_PRESS   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [15:0] VENDOR_PAGE = 16'hFF00;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              remove;   // shift entries at and above the hit down
        logic [KEY_W-1:0]  key;      // key to compare and to append
    } cell_ctl_t;

endpackage

// ===== rtl/hkpr_if.sv =====
// ----------------------------------------------------------------------------
// hkpr_in_if / hkpr_out_if
// Valid/ready channels for report items and key events.
// ----------------------------------------------------------------------------
interface hkpr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [31:0]        top_usage;
    logic [31:0]        usage;
    logic signed [31:0] value;

    modport source (output valid, command, top_usage, usage, value, input ready);
    modport sink   (input valid, command, top_usage, usage, value, output ready);
endinterface

interface hkpr_out_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [31:0] report_usage;
    logic [15:0] key_usage;
    logic        last;

    modport source (output valid, event_kind, report_usage, key_usage, last, input ready);
    modport sink   (input valid, event_kind, report_usage, key_usage, last, output ready);
endinterface

// ===== rtl/hkpr_cell.sv =====
// ----------------------------------------------------------------------------
// hkpr_cell
// One entry of the held-key list: compare, shift down from neighbor, load.
// ----------------------------------------------------------------------------
module hkpr_cell
    import hkpr_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic             occupied,
    input  logic             load,
    input  logic             hit_below,
    input  logic [KEY_W-1:0] upper_key,
    output logic             hit_here_or_below,
    output logic [KEY_W-1:0] key
);

    logic [KEY_W-1:0] key_reg;
    logic             hit;

    assign hit               = occupied && (key_reg == ctl.key);
    assign hit_here_or_below = hit_below || hit;
    assign key               = key_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.remove && hit_here_or_below)
        begin
            key_reg <= upper_key;
        end
        else if (load)
        begin
            key_reg <= ctl.key;
        end
    end

endmodule

// ===== rtl/hid_key_press_release_tracker_core.sv =====
// ----------------------------------------------------------------------------
// hid_key_press_release_tracker_core
// Tracks held keys from HID report items and emits press/release events.
// ----------------------------------------------------------------------------
// Channels: report (sink) takes begin/data/end items; events (source) gives
// key events, each with the current top usage and a last flag.
// Begin items, ignored data, unused commands and ends that release nothing
// finish in idle. A data item is accepted in idle and then searched in the
// cell row, where every entry compares at once and a hit shifts upper
// entries down; the resulting event is registered.
// An end that releases all keys emits one release per held key, up to
// MAX_HELD, reading the top entry of the row for each.
// Items are taken one at a time: report.ready is high only while idle.
// The event register frees a slot when taken; if events is stalled the
// sequencer holds until the slot drains, and no event is dropped.
// Reset clears the key count, top usage and report flags; the list is empty.
// ----------------------------------------------------------------------------
module hid_key_press_release_tracker_core
    import hkpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    hkpr_in_if.sink     report,
    hkpr_out_if.source  events
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RELALL
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      top_reg;
    logic             open_reg;
    logic             seen_reg;
    logic [KEY_W-1:0] key_reg;
    logic             nz_reg;
    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [31:0]      out_usage_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic             out_last_reg;

    cell_ctl_t        ctl;
    logic             slot_free;
    logic             hit_any;
    logic             append;
    logic             emit;
    logic             emit_kind;
    logic [KEY_W-1:0] emit_key;
    logic             emit_last;
    logic             filtered;
    logic [CNT_W-1:0] count_m1;
    logic [IDX_W-1:0] top_idx;
    logic             has_room;

    logic [KEY_W-1:0] cell_key [MAX_HELD];
    logic [MAX_HELD:0] hit_chain;

    assign slot_free = !out_valid_reg || events.ready;
    assign filtered  = (report.usage[31:16] == VENDOR_PAGE) || (report.usage[15:0] == '0);
    assign count_m1  = count_reg - 1'b1;
    assign top_idx   = count_m1[IDX_W-1:0];
    assign has_room  = count_reg < CNT_W'(MAX_HELD);
    assign hit_any   = hit_chain[MAX_HELD];

    assign ctl.key    = key_reg;
    assign ctl.remove = (state_reg == ST_SEARCH) && hit_any && !nz_reg && slot_free;
    assign append     = (state_reg == ST_SEARCH) && !hit_any && nz_reg && slot_free && has_room;

    assign hit_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_HELD; gi++)
        begin : g_cell
            hkpr_cell u_cell (
                .clk               (clk),
                .ctl               (ctl),
                .occupied          (CNT_W'(gi) < count_reg),
                .load              (append && (count_reg == CNT_W'(gi))),
                .hit_below         (hit_chain[gi]),
                .upper_key         (cell_key[(gi + 1 < MAX_HELD) ? gi + 1 : gi]),
                .hit_here_or_below (hit_chain[gi + 1]),
                .key               (cell_key[gi])
            );
        end
    endgenerate

    always_comb
    begin
        emit      = 1'b0;
        emit_kind = KIND_RELEASE;
        emit_key  = key_reg;
        emit_last = 1'b1;
        case (state_reg)
            ST_SEARCH:
            begin
                if (slot_free && (hit_any != nz_reg))
                begin
                    emit      = 1'b1;
                    emit_kind = hit_any ? KIND_RELEASE : KIND_PRESS;
                end
            end
            ST_RELALL:
            begin
                emit      = slot_free;
                emit_key  = cell_key[top_idx];
                emit_last = (count_reg == CNT_W'(1));
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            top_reg       <= '0;
            open_reg      <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (events.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (report.valid)
                    begin
                        case (report.command)
                            CMD_BEGIN:
                            begin
                                top_reg  <= report.top_usage;
                                open_reg <= 1'b1;
                                seen_reg <= 1'b0;
                            end
                            CMD_DATA:
                            begin
                                if (!filtered)
                                begin
                                    seen_reg  <= 1'b1;
                                    state_reg <= ST_SEARCH;
                                end
                            end
                            CMD_END:
                            begin
                                if (open_reg)
                                begin
                                    open_reg <= 1'b0;
                                    if (!seen_reg && (count_reg != '0))
                                    begin
                                        state_reg <= ST_RELALL;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SEARCH:
                begin
                    // listed and still active, or unlisted and inactive: no event
                    if ((hit_any == nz_reg) || slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    if (ctl.remove)
                    begin
                        count_reg <= count_m1;
                    end
                    else if (append)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                ST_RELALL:
                begin
                    if (slot_free)
                    begin
                        count_reg <= count_m1;
                        if (count_reg == CNT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && report.valid)
        begin
            key_reg <= report.usage[15:0];
            nz_reg  <= (report.value != '0);
        end
        if (emit)
        begin
            out_kind_reg  <= emit_kind;
            out_usage_reg <= top_reg;
            out_key_reg   <= emit_key;
            out_last_reg  <= emit_last;
        end
    end

    assign report.ready        = (state_reg == ST_IDLE);
    assign events.valid        = out_valid_reg;
    assign events.event_kind   = out_kind_reg;
    assign events.report_usage = out_usage_reg;
    assign events.key_usage    = out_key_reg;
    assign events.last         = out_last_reg;

endmodule
